/* design/bblf_pkg.sv */
`default_nettype none
package bblf_pkg;

  localparam int NUM_CH_PORTS = 5;

  localparam int RADIUS_W   = 8;
  localparam int CHAN_W     = 3;
  localparam int RECIP_W    = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP    = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_RST   = 8'd4;
  localparam logic [CHAN_W-1:0]   CHANNELS_RST = 3'd4;
  localparam logic [RECIP_W-1:0]  RECIP_RST    = 25'd1864135;

  localparam int ROUND_SHIFT = 24;
  localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);

  localparam int MAX_RADIUS_DEF   = 255;
  localparam int MAX_CHANNELS_DEF = 5;
  localparam int SAMPLE_BITS_DEF  = 16;

endpackage
`default_nettype wire

/* design/bblf_ram.sv */
`default_nettype none
module bblf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 511
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* design/box_blur_line_filter_core.sv */
// Channel  Signals                                   Direction
// in       in_valid_i, in_stall_o, row_start_i,      sink
//          sample_c0_i .. sample_c4_i
// out      out_valid_o, out_stall_i,                 source
//          avg_c0_o .. avg_c4_o
// cfg      cfg_we_i, cfg_addr_i, cfg_wdata_i         sink, write only
//
// One item per cycle sustained while out_stall_i is low.
// Pipeline: input register with window RAM read (one port per channel),
// running-sum update, then multiply by the reciprocal into the result register.
// Reset clears pointer, fill count, sums and valids and loads the config
// defaults; the window RAM is not cleared. An output stall holds the result;
// two further items are absorbed before in_stall_o rises.
`default_nettype none
module box_blur_line_filter_core #(
  parameter int MAX_RADIUS   = bblf_pkg::MAX_RADIUS_DEF,
  parameter int MAX_CHANNELS = bblf_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = bblf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bblf_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [bblf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            row_start_i,
  input  wire logic [SAMPLE_BITS-1:0]          sample_c0_i,
  input  wire logic [SAMPLE_BITS-1:0]          sample_c1_i,
  input  wire logic [SAMPLE_BITS-1:0]          sample_c2_i,
  input  wire logic [SAMPLE_BITS-1:0]          sample_c3_i,
  input  wire logic [SAMPLE_BITS-1:0]          sample_c4_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [SAMPLE_BITS-1:0]          avg_c0_o,
  output logic      [SAMPLE_BITS-1:0]          avg_c1_o,
  output logic      [SAMPLE_BITS-1:0]          avg_c2_o,
  output logic      [SAMPLE_BITS-1:0]          avg_c3_o,
  output logic      [SAMPLE_BITS-1:0]          avg_c4_o
);

  localparam int NCH     = bblf_pkg::NUM_CH_PORTS;
  localparam int SLOTS   = 2 * MAX_RADIUS + 1;
  localparam int PTR_W   = $clog2(SLOTS);
  localparam int LEN_W   = $clog2(SLOTS + 1);
  localparam int SUM_W   = SAMPLE_BITS + 9;
  localparam int PROD_W  = SUM_W + bblf_pkg::RECIP_W;
  localparam int RND_W   = PROD_W + 1;
  localparam int QUO_W   = RND_W - bblf_pkg::ROUND_SHIFT;

  // configuration
  logic [bblf_pkg::RADIUS_W-1:0] radius_q;
  logic [bblf_pkg::CHAN_W-1:0]   chans_q;
  logic [bblf_pkg::RECIP_W-1:0]  recip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= bblf_pkg::RADIUS_RST;
      chans_q  <= bblf_pkg::CHANNELS_RST;
      recip_q  <= bblf_pkg::RECIP_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bblf_pkg::CFG_RADIUS:   radius_q <= cfg_wdata_i[bblf_pkg::RADIUS_W-1:0];
        bblf_pkg::CFG_CHANNELS: chans_q  <= cfg_wdata_i[bblf_pkg::CHAN_W-1:0];
        bblf_pkg::CFG_RECIP:    recip_q  <= cfg_wdata_i[bblf_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0]              len;
  logic [bblf_pkg::CHAN_W-1:0]   nch;
  logic [MAX_CHANNELS-1:0]       act;

  always_comb begin
    if (int'(radius_q) > MAX_RADIUS) begin
      len = LEN_W'(SLOTS);
    end else begin
      len = LEN_W'({radius_q, 1'b1});
    end
    if (chans_q == '0) begin
      nch = bblf_pkg::CHAN_W'(1);
    end else if (int'(chans_q) > MAX_CHANNELS) begin
      nch = bblf_pkg::CHAN_W'(MAX_CHANNELS);
    end else begin
      nch = chans_q;
    end
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      act[c] = int'(nch) > c;
    end
  end

  logic [SAMPLE_BITS-1:0] smp_in [NCH];
  assign smp_in[0] = sample_c0_i;
  assign smp_in[1] = sample_c1_i;
  assign smp_in[2] = sample_c2_i;
  assign smp_in[3] = sample_c3_i;
  assign smp_in[4] = sample_c4_i;

  // pipeline control
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_row_q, s1_full_q, s1_emit_q;
  logic [PTR_W-1:0] s1_ptr_q;
  logic [SAMPLE_BITS-1:0] s1_smp_q [MAX_CHANNELS];

  logic s3_en, s2_free, s1_move, accept;

  assign s3_en      = !s3_valid_q || !out_stall_i;
  assign s2_free    = !s2_valid_q || s3_en;
  assign s1_move    = s1_valid_q && (!s1_emit_q || s2_free);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign accept     = in_valid_i && !in_stall_o;

  // window position for the incoming item
  logic [PTR_W-1:0] ptr_q, ptr_base, ptr0, ptr_nx;
  logic [LEN_W-1:0] fill_q, fill_base, fill0, fill_nx, ptr_inc;
  logic             full0, emit0;

  always_comb begin
    ptr_base  = row_start_i ? '0 : ptr_q;
    ptr0      = (LEN_W'(ptr_base) >= len) ? '0 : ptr_base;
    fill_base = row_start_i ? '0 : fill_q;
    fill0     = (fill_base > len) ? len : fill_base;
    full0     = fill0 == len;
    ptr_inc   = LEN_W'(ptr0) + LEN_W'(1);
    ptr_nx    = (ptr_inc >= len) ? '0 : ptr_inc[PTR_W-1:0];
    fill_nx   = (fill0 < len) ? fill0 + LEN_W'(1) : fill0;
    emit0     = fill_nx == len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
    end else if (accept) begin
      ptr_q  <= ptr_nx;
      fill_q <= fill_nx;
    end
  end

  // read of a slot being written by the item ahead
  logic                   byp_q;
  logic [SAMPLE_BITS-1:0] byp_smp_q [MAX_CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      byp_q      <= s1_move && (s1_ptr_q == ptr0);
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q  <= row_start_i;
      s1_full_q <= full0;
      s1_emit_q <= emit0;
      s1_ptr_q  <= ptr0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        s1_smp_q[c]  <= smp_in[c];
        byp_smp_q[c] <= s1_smp_q[c];
      end
    end
  end

  // running sums and result stages
  logic [SUM_W-1:0]       sum_q    [MAX_CHANNELS];
  logic [SUM_W-1:0]       sum_nx   [MAX_CHANNELS];
  logic [SUM_W-1:0]       s2_sum_q [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0] avg_nx   [NCH];
  logic [SAMPLE_BITS-1:0] avg_q    [NCH];

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : gen_ch
    logic [SAMPLE_BITS-1:0] rd, old;
    logic [SUM_W-1:0]       base;
    logic [PROD_W-1:0]      prod;
    logic [RND_W-1:0]       rnd;
    logic [QUO_W-1:0]       quo;

    bblf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (SLOTS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (s1_move && act[c]),
      .waddr_i (s1_ptr_q),
      .wdata_i (s1_smp_q[c]),
      .re_i    (accept),
      .raddr_i (ptr0),
      .rdata_o (rd)
    );

    always_comb begin
      old  = byp_q ? byp_smp_q[c] : rd;
      base = s1_row_q ? '0 : sum_q[c];
      if (act[c]) begin
        sum_nx[c] = base - (s1_full_q ? SUM_W'(old) : '0) + SUM_W'(s1_smp_q[c]);
      end else begin
        sum_nx[c] = base;
      end
    end

    assign prod = PROD_W'(s2_sum_q[c]) * PROD_W'(recip_q);
    assign rnd  = RND_W'(prod) + RND_W'(bblf_pkg::ROUND_HALF);
    assign quo  = rnd[RND_W-1:bblf_pkg::ROUND_SHIFT];

    always_comb begin
      if (!act[c]) begin
        avg_nx[c] = '0;
      end else if (quo > QUO_W'({SAMPLE_BITS{1'b1}})) begin
        avg_nx[c] = '1;
      end else begin
        avg_nx[c] = quo[SAMPLE_BITS-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sum_q[c] <= '0;
      end else if (s1_move) begin
        sum_q[c] <= sum_nx[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (s1_move && s1_emit_q) begin
        s2_sum_q[c] <= sum_nx[c];
      end
    end
  end

  for (genvar c = MAX_CHANNELS; c < NCH; c++) begin : gen_unused
    assign avg_nx[c] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= s1_move && s1_emit_q;
      end
      if (s3_en) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_valid_q) begin
      for (int c = 0; c < NCH; c++) begin
        avg_q[c] <= avg_nx[c];
      end
    end
  end

  assign out_valid_o = s3_valid_q;
  assign avg_c0_o    = avg_q[0];
  assign avg_c1_o    = avg_q[1];
  assign avg_c2_o    = avg_q[2];
  assign avg_c3_o    = avg_q[3];
  assign avg_c4_o    = avg_q[4];

endmodule
`default_nettype wire

/* design/bblf_checker.sv */
`default_nettype none
module bblf_checker #(
  parameter int SAMPLE_BITS = bblf_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            cfg_we_i,
  input wire logic [bblf_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input wire logic [bblf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [SAMPLE_BITS-1:0]          avg_c0_o,
  input wire logic [SAMPLE_BITS-1:0]          avg_c4_o
);

  logic [bblf_pkg::CHAN_W-1:0] chans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chans_q <= bblf_pkg::CHANNELS_RST;
    end else if (cfg_we_i && (cfg_addr_i == bblf_pkg::CFG_CHANNELS)) begin
      chans_q <= cfg_wdata_i[bblf_pkg::CHAN_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(avg_c0_o) && $stable(avg_c4_o))
    else $error("stalled result changed");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output side free");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (chans_q < bblf_pkg::CHAN_W'(5)) |-> avg_c4_o == '0)
    else $error("unused channel gave a non-zero average");

endmodule

bind box_blur_line_filter_core bblf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bblf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_addr_i  (cfg_addr_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .avg_c0_o    (avg_c0_o),
  .avg_c4_o    (avg_c4_o)
);
`default_nettype wire

/* verif/tb.sv */
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB          = bblf_pkg::SAMPLE_BITS_DEF;
  localparam int NCH         = bblf_pkg::NUM_CH_PORTS;
  localparam int MAXCH       = bblf_pkg::MAX_CHANNELS_DEF;
  localparam int SLOT_COUNT  = 2 * bblf_pkg::MAX_RADIUS_DEF + 1;
  localparam int STORE_WORDS = SLOT_COUNT * MAXCH;
  localparam int LONG_RADIUS = 80;
  localparam int LONG_LEN    = 2 * LONG_RADIUS + 1;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 8;
  localparam int IDX_W       = bblf_pkg::CFG_IDX_W;
  localparam int DATA_W      = bblf_pkg::CFG_DATA_W;
  localparam int RCP_W       = bblf_pkg::RECIP_W;
  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic                   row_start;
    logic [NCH-1:0][SB-1:0] s;
  } pixel_t;

  typedef logic [NCH-1:0][SB-1:0] averages_t;

  class window_average_tracker;
    logic [SB-1:0]                 store [STORE_WORDS];
    bit                            written [STORE_WORDS];
    logic [SB+8:0]                 sums [MAXCH];
    int unsigned                   fill;
    int unsigned                   ptr;
    logic [bblf_pkg::RADIUS_W-1:0] radius;
    logic [bblf_pkg::CHAN_W-1:0]   chans;
    logic [RCP_W-1:0]              recip;
    averages_t                     pending_averages [$];
    int                            errors;

    function new();
      radius = bblf_pkg::RADIUS_RST;
      chans  = bblf_pkg::CHANNELS_RST;
      recip  = bblf_pkg::RECIP_RST;
      fill   = 0;
      ptr    = 0;
      errors = 0;
      foreach (sums[c]) sums[c] = '0;
      foreach (written[i]) begin
        written[i] = 1'b0;
        store[i]   = '0;
      end
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        bblf_pkg::CFG_RADIUS:   radius = val[bblf_pkg::RADIUS_W-1:0];
        bblf_pkg::CFG_CHANNELS: chans  = val[bblf_pkg::CHAN_W-1:0];
        bblf_pkg::CFG_RECIP:    recip  = val[RCP_W-1:0];
        default:      ;
      endcase
    endfunction

    function int unsigned win_len();
      int unsigned r;
      r = (radius > bblf_pkg::MAX_RADIUS_DEF) ? bblf_pkg::MAX_RADIUS_DEF : radius;
      return 2 * r + 1;
    endfunction

    function int unsigned active_ch();
      if (chans == 0) return 1;
      if (chans > MAXCH) return MAXCH;
      return chans;
    endfunction

    // true when continuing the row would read a slot never written
    function bit needs_restart();
      int unsigned len, p, f;
      len = win_len();
      p   = (ptr >= len) ? 0 : ptr;
      f   = (fill > len) ? len : fill;
      if (f != len) return 1'b0;
      for (int c = 0; c < active_ch(); c++)
        if (!written[p * MAXCH + c]) return 1'b1;
      return 1'b0;
    endfunction

    function void accept_pixel(pixel_t px);
      int unsigned len, nch, idx;
      bit          full;
      logic [63:0] prod;
      averages_t   avg;
      len = win_len();
      nch = active_ch();
      if (px.row_start) begin
        fill = 0;
        ptr  = 0;
        foreach (sums[c]) sums[c] = '0;
      end
      if (ptr >= len) ptr = 0;
      if (fill > len) fill = len;
      full = (fill == len);
      for (int c = 0; c < nch; c++) begin
        idx = ptr * MAXCH + c;
        if (full) sums[c] = sums[c] - store[idx];
        sums[c] = sums[c] + px.s[c];
        store[idx]   = px.s[c];
        written[idx] = 1'b1;
      end
      ptr++;
      if (ptr >= len) ptr = 0;
      if (fill < len) fill++;
      if (fill != len) return;
      for (int c = 0; c < NCH; c++) begin
        avg[c] = '0;
        if (c < nch) begin
          prod = 64'(sums[c]) * 64'(recip) + 64'(bblf_pkg::ROUND_HALF);
          prod = prod >> bblf_pkg::ROUND_SHIFT;
          avg[c] = (prod > 64'hFFFF) ? 16'hFFFF : prod[SB-1:0];
        end
      end
      pending_averages.push_back(avg);
    endfunction

    function void check_average(averages_t got);
      averages_t exp;
      if (pending_averages.size() == 0) begin
        $display("%0t unexpected item: got %h", $time, got);
        errors++;
        return;
      end
      exp = pending_averages.pop_front();
      for (int c = 0; c < NCH; c++)
        if (exp[c] !== got[c]) begin
          $display("%0t avg_c%0d expected %h got %h", $time, c, exp[c], got[c]);
          errors++;
        end
    endfunction

    function int pending();
      return pending_averages.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [IDX_W-1:0]  cfg_addr_i;
  logic [DATA_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              row_start_i;
  logic [SB-1:0]     sample_c0_i, sample_c1_i, sample_c2_i, sample_c3_i, sample_c4_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [SB-1:0]     avg_c0_o, avg_c1_o, avg_c2_o, avg_c3_o, avg_c4_o;

  window_average_tracker tracker = new();
  idle_mode_e idle_mode = IDLE_NONE;
  int         quiet_cycles = 0;

  box_blur_line_filter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .row_start_i (row_start_i),
    .sample_c0_i (sample_c0_i),
    .sample_c1_i (sample_c1_i),
    .sample_c2_i (sample_c2_i),
    .sample_c3_i (sample_c3_i),
    .sample_c4_i (sample_c4_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .avg_c0_o    (avg_c0_o),
    .avg_c1_o    (avg_c1_o),
    .avg_c2_o    (avg_c2_o),
    .avg_c3_o    (avg_c3_o),
    .avg_c4_o    (avg_c4_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(negedge clk_i) begin
    case (idle_mode)
      IDLE_RECV: out_stall_i <= ($urandom_range(0, 99) < 46);
      IDLE_BOTH: out_stall_i <= ($urandom_range(0, 99) < 31);
      default:   out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      tracker.check_average({avg_c4_o, avg_c3_o, avg_c2_o, avg_c1_o, avg_c0_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)
        || cfg_we_i || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no progress, %0d items outstanding", $time, tracker.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return ($urandom_range(0, 99) < 46);
      IDLE_BOTH: return ($urandom_range(0, 99) < 31);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic pixel_t flat_pixel(bit rs, logic [SB-1:0] v);
    pixel_t p;
    p.row_start = rs;
    for (int c = 0; c < NCH; c++) p.s[c] = v;
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     kind;
    kind = $urandom_range(0, 7);
    p.row_start = 1'b0;
    for (int c = 0; c < NCH; c++)
      p.s[c] = (kind == 0) ? 16'hFFFF : (kind == 1) ? 16'h0000 : SB'($urandom);
    return p;
  endfunction

  function automatic logic [RCP_W-1:0] nearest_recip(int unsigned len);
    return RCP_W'(((32'd1 << 25) / len + 1) / 2);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(pixel_t p);
    while (sender_gap()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    row_start_i <= p.row_start;
    sample_c0_i <= p.s[0];
    sample_c1_i <= p.s[1];
    sample_c2_i <= p.s[2];
    sample_c3_i <= p.s[3];
    sample_c4_i <= p.s[4];
    forever begin
      @(posedge clk_i);
      if (in_stall_o === 1'b0) break;
    end
    tracker.accept_pixel(p);
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    if (tracker.pending() != 0) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (tracker.pending() != 0);
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    idle_mode = IDLE_NONE;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic program_filter(int r, int ch, logic [RCP_W-1:0] rcp, bit poke_unused);
    logic [IDX_W-1:0]  idx [4];
    logic [DATA_W-1:0] val [4];
    int                n;
    idx[0] = bblf_pkg::CFG_RADIUS;   val[0] = DATA_W'(r);
    idx[1] = bblf_pkg::CFG_CHANNELS; val[1] = DATA_W'(ch);
    idx[2] = bblf_pkg::CFG_RECIP;    val[2] = DATA_W'(rcp);
    idx[3] = CFG_UNUSED;             val[3] = DATA_W'($urandom);
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx[i];
      cfg_wdata_i <= val[i];
      tracker.write_reg(idx[i], val[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_phase(idle_mode_e mode, bit wide);
    int               r, ch, len, n, kind, row_left;
    logic [RCP_W-1:0] rcp;
    pixel_t           p;
    bit               carry_on;
    kind = $urandom_range(0, 9);
    r    = wide ? $urandom_range(7, 16) : $urandom_range(0, 6);
    ch   = $urandom_range(0, 7);
    len  = 2 * r + 1;
    case (kind)
      0, 1:    rcp = RCP_W'($urandom);
      2:       rcp = '0;
      3:       rcp = RCP_W'(1 << 24);
      default: rcp = nearest_recip(len);
    endcase
    quiesce();
    program_filter(r, ch, rcp, kind == 4);
    idle_mode = mode;
    n        = wide ? 2 * len + 20 : 24;
    carry_on = ($urandom_range(0, 2) == 0);
    row_left = 0;
    for (int k = 0; k < n; k++) begin
      p = random_pixel();
      if (row_left == 0) begin
        row_left    = len + $urandom_range(0, 8);
        p.row_start = !(k == 0 && carry_on);
      end else begin
        p.row_start = ($urandom_range(0, 19) == 0);
      end
      row_left--;
      if (!p.row_start && tracker.needs_restart()) p.row_start = 1'b1;
      if ($urandom_range(0, 39) == 0 || k == n / 2) hold_until_drained();
      send_item(p);
    end
  endtask

  initial begin
    pixel_t p;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    row_start_i = 1'b0;
    sample_c0_i = '0;
    sample_c1_i = '0;
    sample_c2_i = '0;
    sample_c3_i = '0;
    sample_c4_i = '0;
    out_stall_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: full-scale window, then zeros pushed through
    for (int k = 0; k < 11; k++) send_item(flat_pixel(k == 0, (k < 9) ? 16'hFFFF : 16'h0000));

    // single-pixel window, unity scale
    quiesce();
    program_filter(0, 5, RCP_W'(1 << 24), 1'b1);
    send_item(flat_pixel(1'b1, 16'hFFFF));
    send_item(flat_pixel(1'b0, 16'h0000));
    send_item(flat_pixel(1'b1, 16'h8000));
    send_item(random_pixel());

    // channel count zero, scale beyond one: saturation
    quiesce();
    program_filter(0, 0, '1, 1'b0);
    send_item(flat_pixel(1'b1, 16'h0001));
    send_item(flat_pixel(1'b0, 16'hFFFF));

    // channel count above the maximum, half scale: ties round up
    quiesce();
    program_filter(0, 7, RCP_W'(1 << 23), 1'b0);
    send_item(flat_pixel(1'b1, 16'h0001));
    send_item(flat_pixel(1'b0, 16'h0003));

    // three-pixel window, six channels requested
    quiesce();
    program_filter(1, 6, nearest_recip(3), 1'b0);
    for (int k = 0; k < 4; k++) begin
      p = random_pixel();
      p.row_start = (k == 0);
      send_item(p);
    end

    for (int ph = 0; ph < 8; ph++)
      random_phase(idle_mode_e'(ph % 4), ph == 3 || ph == 6);

    // long window, one padded row
    quiesce();
    program_filter(LONG_RADIUS, 5, nearest_recip(LONG_LEN), 1'b1);
    idle_mode = IDLE_BOTH;
    for (int k = 0; k < LONG_LEN + 12; k++) begin
      p = random_pixel();
      p.row_start = (k == 0) || tracker.needs_restart();
      send_item(p);
    end

    quiesce();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
design/bblf_pkg.sv
design/bblf_ram.sv
design/box_blur_line_filter_core.sv
design/bblf_checker.sv
verif/tb.sv
